### design/lssr_pkg.sv
package lssr_pkg;

    // Default build of the sensor line and the ADC sample set.
    localparam int PIXELS_DEF  = 128;
    localparam int SPP_DEF     = 8;
    localparam int SBITS_DEF   = 16;

    // Fixed port widths.
    localparam int SAMPLE_W    = 16;
    localparam int MAX_SAMPLES = 8;
    localparam int RIDX_W      = 7;
    localparam int REQ_W       = 2;
    localparam int CFG_W       = 8;

    localparam logic [CFG_W-1:0] END_WAIT_RST = 8'd2;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK = 2'd0,
        REQ_ADC  = 2'd1,
        REQ_READ = 2'd2
    } t_req;

    typedef enum logic [3:0] {
        PH_START     = 4'd0,
        PH_SI_UP     = 4'd1,
        PH_FCLK_UP   = 4'd2,
        PH_SI_DOWN   = 4'd3,
        PH_FCLK_DOWN = 4'd4,
        PH_WAIT_A    = 4'd5,
        PH_WAIT_B    = 4'd6,
        PH_CLK_UP    = 4'd7,
        PH_CLK_DOWN  = 4'd8,
        PH_END_WAIT  = 4'd9
    } t_phase;

    typedef enum logic [1:0] {
        CTL_IDLE     = 2'd0,
        CTL_MEAN_MUL = 2'd1,
        CTL_MEAN_WR  = 2'd2,
        CTL_READ     = 2'd3
    } t_ctl;

    // Sensor pin levels and tick pulses as they stand after the current beat.
    typedef struct packed {
        logic si;
        logic clk;
        logic adc_start;
        logic frame_done;
    } t_pins;

endpackage

### design/lssr_seq.sv
module lssr_seq #(
    parameter int PIXELS = lssr_pkg::PIXELS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_tick,
    input  logic                      i_cfg_we,
    input  logic [lssr_pkg::CFG_W-1:0] i_cfg_data,
    output lssr_pkg::t_pins           o_pins,
    output logic                      o_pos_active,
    output logic [$clog2(PIXELS)-1:0] o_pos_idx
);
    import lssr_pkg::*;

    localparam int IDX_W = $clog2(PIXELS);
    localparam int POS_W = $clog2(PIXELS + 1);
    localparam logic [POS_W-1:0] POS_END = POS_W'(PIXELS);

    t_phase             r_phase, n_phase;
    logic               r_pos_none, n_pos_none;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [CFG_W-1:0]   r_wait_cnt, n_wait_cnt;
    logic [CFG_W-1:0]   r_end_wait;
    logic               r_si, n_si;
    logic               r_clk, n_clk;
    logic               w_adc, w_done;
    logic [POS_W-1:0]   w_pos_inc;
    logic               w_pos_end;
    logic [CFG_W-1:0]   w_wait_inc;
    logic               w_wait_over;

    // Leaving the "no pixel" position lands on pixel zero.
    assign w_pos_inc   = r_pos_none ? '0 : r_pos + POS_W'(1);
    assign w_pos_end   = (w_pos_inc >= POS_END);
    assign w_wait_inc  = r_wait_cnt + CFG_W'(1);
    assign w_wait_over = (w_wait_inc >= r_end_wait);

    always_comb begin
        n_phase = r_phase;
        if (i_tick) begin
            case (r_phase)
                PH_START:     n_phase = PH_SI_UP;
                PH_SI_UP:     n_phase = PH_FCLK_UP;
                PH_FCLK_UP:   n_phase = PH_SI_DOWN;
                PH_SI_DOWN:   n_phase = PH_FCLK_DOWN;
                PH_FCLK_DOWN: n_phase = PH_WAIT_A;
                PH_WAIT_A:    n_phase = PH_WAIT_B;
                PH_WAIT_B:    n_phase = PH_CLK_UP;
                PH_CLK_UP:    n_phase = w_pos_end ? PH_END_WAIT : PH_CLK_DOWN;
                PH_CLK_DOWN:  n_phase = PH_CLK_UP;
                PH_END_WAIT:  n_phase = w_wait_over ? PH_START : PH_END_WAIT;
                default:      n_phase = r_phase;
            endcase
        end
    end

    always_comb begin
        n_si       = r_si;
        n_clk      = r_clk;
        n_pos_none = r_pos_none;
        n_pos      = r_pos;
        n_wait_cnt = r_wait_cnt;
        w_adc      = 1'b0;
        w_done     = 1'b0;
        if (i_tick) begin
            case (r_phase)
                PH_SI_UP:   n_si = 1'b1;
                PH_FCLK_UP: n_clk = 1'b1;
                PH_SI_DOWN: n_si = 1'b0;
                PH_FCLK_DOWN: begin
                    n_clk      = 1'b0;
                    n_pos_none = 1'b1;
                    n_wait_cnt = '0;
                end
                PH_CLK_UP: begin
                    n_pos_none = 1'b0;
                    n_pos      = w_pos_inc;
                    if (w_pos_end) begin
                        w_done = 1'b1;
                    end else begin
                        n_clk = 1'b1;
                    end
                end
                PH_CLK_DOWN: begin
                    w_adc = 1'b1;
                    n_clk = 1'b0;
                end
                PH_END_WAIT: n_wait_cnt = w_wait_over ? '0 : w_wait_inc;
                default: begin
                    n_si = r_si;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_START;
            r_pos_none <= 1'b1;
            r_pos      <= '0;
            r_wait_cnt <= '0;
            r_si       <= 1'b0;
            r_clk      <= 1'b0;
            r_end_wait <= END_WAIT_RST;
        end else begin
            r_phase    <= n_phase;
            r_pos_none <= n_pos_none;
            r_pos      <= n_pos;
            r_wait_cnt <= n_wait_cnt;
            r_si       <= n_si;
            r_clk      <= n_clk;
            if (i_cfg_we) begin
                r_end_wait <= i_cfg_data;
            end
        end
    end

    assign o_pins.si         = n_si;
    assign o_pins.clk        = n_clk;
    assign o_pins.adc_start  = w_adc;
    assign o_pins.frame_done = w_done;
    assign o_pos_active      = !r_pos_none && (r_pos < POS_END);
    assign o_pos_idx         = r_pos[IDX_W-1:0];

endmodule

### design/lssr_mean.sv
module lssr_mean #(
    parameter int SAMPLES_PER_PIXEL = lssr_pkg::SPP_DEF,
    parameter int SAMPLE_BITS       = lssr_pkg::SBITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  logic [lssr_pkg::SAMPLE_W-1:0] i_samples [lssr_pkg::MAX_SAMPLES],
    output logic [SAMPLE_BITS-1:0]       o_mean
);
    import lssr_pkg::*;

    // Division by the sample count is a multiply by a rounded-up reciprocal,
    // exact for every sum that fits SUM_W bits.
    localparam int LOG_N   = $clog2(SAMPLES_PER_PIXEL);
    localparam int SUM_W   = SAMPLE_BITS + LOG_N;
    localparam int SHIFT   = SUM_W + LOG_N;
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + SAMPLES_PER_PIXEL - 1) / SAMPLES_PER_PIXEL);

    logic [SUM_W-1:0]  n_sum, r_sum;
    logic [PROD_W-1:0] r_prod;

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < SAMPLES_PER_PIXEL; k++) begin
            n_sum = n_sum + SUM_W'(i_samples[k][SAMPLE_BITS-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sum <= n_sum;
        end
        r_prod <= PROD_W'(r_sum) * PROD_W'(RECIP);
    end

    assign o_mean = r_prod[SHIFT +: SAMPLE_BITS];

endmodule

### design/lssr_store.sv
module lssr_store #(
    parameter int PIXELS      = lssr_pkg::PIXELS_DEF,
    parameter int SAMPLE_BITS = lssr_pkg::SBITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [$clog2(PIXELS)-1:0] i_waddr,
    input  logic [SAMPLE_BITS-1:0]    i_wdata,
    input  logic                      i_re,
    input  logic [$clog2(PIXELS)-1:0] i_raddr,
    output logic [SAMPLE_BITS-1:0]    o_rdata
);
    import lssr_pkg::*;

    logic [SAMPLE_BITS-1:0] r_mem [PIXELS];
    logic [SAMPLE_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/line_scan_sensor_readout_unit.sv
// Line scan sensor readout unit.
// Command channel: an item is taken at a rising edge with start high and busy
// low. A tick item steps the SI / pixel clock sequencer by one phase, an ADC
// item stores the truncated mean of its sample set at the active pixel, and a
// read item returns one stored pixel.
// Result channel: each accepted item yields exactly one result beat, shown for
// one cycle with o_valid high. The receiver cannot hold it off.
// Timing from the accepting edge to the result beat: ticks and unknown
// requests show it in the cycle after that edge; reads first pass the
// synchronous store read, and ADC items the sum stage, then the reciprocal
// multiply stage, then the store write. Throughput: ticks run one per cycle
// while busy is low; a read or ADC item holds busy until done. Configuration:
// the end-of-line wait count is written on its own valid/ready channel, always
// ready; the user must write it only while the unit is idle (not enforced).
// Reset puts the sequencer in its start phase with both pins low and no
// active pixel; the pixel store is not cleared and needs no clearing pass.
module line_scan_sensor_readout_unit #(
    parameter int PIXELS            = lssr_pkg::PIXELS_DEF,
    parameter int SAMPLES_PER_PIXEL = lssr_pkg::SPP_DEF,
    parameter int SAMPLE_BITS       = lssr_pkg::SBITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [lssr_pkg::REQ_W-1:0]    i_req_type,
    input  logic [lssr_pkg::SAMPLE_W-1:0] i_sample_0,
    input  logic [lssr_pkg::SAMPLE_W-1:0] i_sample_1,
    input  logic [lssr_pkg::SAMPLE_W-1:0] i_sample_2,
    input  logic [lssr_pkg::SAMPLE_W-1:0] i_sample_3,
    input  logic [lssr_pkg::SAMPLE_W-1:0] i_sample_4,
    input  logic [lssr_pkg::SAMPLE_W-1:0] i_sample_5,
    input  logic [lssr_pkg::SAMPLE_W-1:0] i_sample_6,
    input  logic [lssr_pkg::SAMPLE_W-1:0] i_sample_7,
    input  logic [lssr_pkg::RIDX_W-1:0]   i_read_index,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lssr_pkg::CFG_W-1:0]    i_cfg_data,
    output logic                          o_valid,
    output logic                          o_si_level,
    output logic                          o_clock_level,
    output logic                          o_adc_start,
    output logic                          o_frame_done,
    output logic [lssr_pkg::SAMPLE_W-1:0] o_pixel_value
);
    import lssr_pkg::*;

    localparam int IDX_W = $clog2(PIXELS);

    t_ctl                   r_state, n_state;
    logic                   w_accept;
    logic                   w_tick;
    logic                   w_mean_load;
    logic                   w_rd_en;
    logic                   w_emit;
    logic                   w_we;
    logic                   w_rd_oob;
    logic                   r_rd_oob;
    logic [SAMPLE_W-1:0]    n_pix;
    logic [SAMPLE_W-1:0]    w_samples [MAX_SAMPLES];
    logic [SAMPLE_BITS-1:0] w_mean;
    logic [SAMPLE_BITS-1:0] w_rdata;
    t_pins                  w_pins;
    logic                   w_pos_active;
    logic [IDX_W-1:0]       w_pos_idx;

    logic                   r_valid;
    t_pins                  r_pins;
    logic [SAMPLE_W-1:0]    r_pix;

    assign w_accept    = start && !busy;
    assign o_cfg_ready = 1'b1;

    assign w_samples[0] = i_sample_0;
    assign w_samples[1] = i_sample_1;
    assign w_samples[2] = i_sample_2;
    assign w_samples[3] = i_sample_3;
    assign w_samples[4] = i_sample_4;
    assign w_samples[5] = i_sample_5;
    assign w_samples[6] = i_sample_6;
    assign w_samples[7] = i_sample_7;

    // Reads past the end of a short line return zero.
    assign w_rd_oob = (int'(i_read_index) >= PIXELS);

    lssr_seq #(
        .PIXELS (PIXELS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (w_tick),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_pins       (w_pins),
        .o_pos_active (w_pos_active),
        .o_pos_idx    (w_pos_idx)
    );

    lssr_mean #(
        .SAMPLES_PER_PIXEL (SAMPLES_PER_PIXEL),
        .SAMPLE_BITS       (SAMPLE_BITS)
    ) u_mean (
        .i_clk     (i_clk),
        .i_load    (w_mean_load),
        .i_samples (w_samples),
        .o_mean    (w_mean)
    );

    lssr_store #(
        .PIXELS      (PIXELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_pos_idx),
        .i_wdata (w_mean),
        .i_re    (w_rd_en),
        .i_raddr (IDX_W'(i_read_index)),
        .o_rdata (w_rdata)
    );

    // Next state of the item controller.
    always_comb begin
        n_state = r_state;
        case (r_state)
            CTL_IDLE: begin
                if (w_accept) begin
                    case (i_req_type)
                        REQ_ADC:  n_state = CTL_MEAN_MUL;
                        REQ_READ: n_state = CTL_READ;
                        default:  n_state = CTL_IDLE;
                    endcase
                end
            end
            CTL_MEAN_MUL: n_state = CTL_MEAN_WR;
            CTL_MEAN_WR:  n_state = CTL_IDLE;
            CTL_READ:     n_state = CTL_IDLE;
            default:      n_state = CTL_IDLE;
        endcase
    end

    // Controller outputs. A write into the store happens in the last mean cycle
    // and only while a pixel is active; a later read is held off by busy, so
    // the store never sees a read and a write of one entry in flight together.
    always_comb begin
        busy        = (r_state != CTL_IDLE);
        w_tick      = w_accept && (i_req_type == REQ_TICK);
        w_mean_load = w_accept && (i_req_type == REQ_ADC);
        w_rd_en     = w_accept && (i_req_type == REQ_READ);
        w_emit      = 1'b0;
        w_we        = 1'b0;
        n_pix       = '0;
        case (r_state)
            CTL_IDLE: begin
                w_emit = w_accept && (i_req_type != REQ_ADC) && (i_req_type != REQ_READ);
            end
            CTL_MEAN_WR: begin
                w_emit = 1'b1;
                w_we   = w_pos_active;
            end
            CTL_READ: begin
                w_emit = 1'b1;
                n_pix  = r_rd_oob ? '0 : SAMPLE_W'(w_rdata);
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CTL_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= w_emit;
        end
    end

    // Result payload. Outside a tick the sequencer reports the held pin levels
    // with both pulses low, which is what reads and ADC beats carry.
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_oob <= w_rd_oob;
        end
        if (w_emit) begin
            r_pins <= w_pins;
            r_pix  <= n_pix;
        end
    end

    assign o_valid       = r_valid;
    assign o_si_level    = r_pins.si;
    assign o_clock_level = r_pins.clk;
    assign o_adc_start   = r_pins.adc_start;
    assign o_frame_done  = r_pins.frame_done;
    assign o_pixel_value = r_pix;

    a_tick_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req_type == REQ_TICK)) |=> o_valid)
        else $error("tick item did not give a result beat on the next cycle");

    a_beat_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == CTL_IDLE))
        else $error("result beat shown while an item is still in progress");

    a_mean_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == CTL_MEAN_MUL) |=> ((r_state == CTL_MEAN_WR) ##1 o_valid))
        else $error("ADC item did not finish with a result beat");

    a_pulse_clk_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_adc_start || o_frame_done)) |-> !o_clock_level)
        else $error("ADC start or frame done shown with the pixel clock high");

    a_write_idle_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (!w_tick && busy))
        else $error("store written outside the mean write cycle");

endmodule
